FILE: sv/gpsp_pkg.sv
// ============================================================================
// gpsp_pkg
// Shared types, constants and command-byte helpers for the gamepad poll master.
// ============================================================================
package gpsp_pkg;

    localparam int FRAME_LEN   = 9;
    localparam int SHORT_POLLS = 3;
    localparam int SHORT_LEN   = 5;
    localparam int CHECK_LEN   = 2;
    localparam int REPLY_DEPTH = 9;

    localparam int BYTE_W = $clog2(FRAME_LEN + 1);
    localparam int STEP_W = $clog2(SHORT_POLLS + 3);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [7:0] CMD_START   = 8'h01;
    localparam logic [7:0] CMD_POLL    = 8'h42;
    localparam logic [7:0] CMD_CONFIG  = 8'h43;
    localparam logic [7:0] CMD_SETMODE = 8'h44;
    localparam logic [7:0] ENTER_ON    = 8'h01;
    localparam logic [7:0] MODE_ANALOG = 8'h01;
    localparam logic [7:0] MODE_DIGITAL = 8'h00;
    localparam logic [7:0] LOCK_CODE   = 8'h03;
    localparam logic [7:0] UNLOCK_CODE = 8'hEE;
    localparam logic [7:0] EXIT_PAD    = 8'h5A;
    localparam logic [7:0] ID_ANALOG   = 8'h73;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_POLL  = 3'd1,
        ACT_MOTOR = 3'd2,
        ACT_INIT  = 3'd3,
        ACT_CHECK = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_ENTER = 2'd1,
        KIND_MODE  = 2'd2,
        KIND_EXIT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ANALOG_SELECT = 2'd0,
        REG_MODE_LOCK     = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic analog_select;
        logic mode_lock;
    } cfg_t;

    // One classified bit slot on its way from the front to the engine.
    typedef struct packed {
        logic       start;
        action_t    action;
        logic [7:0] motor_small;
        logic [7:0] motor_large;
        logic       miso;
    } cmd_t;

    typedef struct packed {
        logic        select_active;
        logic        mosi;
        logic        busy_res;
        logic        frame_done;
        logic [15:0] buttons;
        logic [4:0]  pressed_key;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  mode_byte;
        logic        not_analog;
    } result_t;

    function automatic kind_t init_kind(input logic [STEP_W-1:0] step);
        kind_t k;
        if (int'(step) < SHORT_POLLS)
            k = KIND_SHORT;
        else
            k = kind_t'(2'(int'(step) - SHORT_POLLS + 1));
        return k;
    endfunction

    function automatic logic [BYTE_W-1:0] frame_len(input action_t act,
                                                    input logic [STEP_W-1:0] step);
        logic [BYTE_W-1:0] len;
        if (act == ACT_CHECK)
            len = BYTE_W'(CHECK_LEN);
        else if (act == ACT_INIT && init_kind(step) == KIND_SHORT)
            len = BYTE_W'(SHORT_LEN);
        else
            len = BYTE_W'(FRAME_LEN);
        return len;
    endfunction

    function automatic logic [7:0] cmd_byte(input action_t act,
                                            input logic [STEP_W-1:0] step,
                                            input logic [BYTE_W-1:0] b,
                                            input logic [7:0] small_m,
                                            input logic [7:0] large_m,
                                            input cfg_t cfg);
        int bi;
        logic [7:0] cb;
        bi = int'(b);
        cb = 8'h00;
        if (bi == 0) begin
            cb = CMD_START;
        end else if (act != ACT_INIT) begin
            if (bi == 1)
                cb = CMD_POLL;
            else if (act == ACT_MOTOR && bi == 3)
                cb = small_m;
            else if (act == ACT_MOTOR && bi == 4)
                cb = large_m;
        end else begin
            unique case (init_kind(step))
                KIND_SHORT:
                begin
                    if (bi == 1) cb = CMD_POLL;
                end
                KIND_ENTER:
                begin
                    if (bi == 1) cb = CMD_CONFIG;
                    else if (bi == 3) cb = ENTER_ON;
                end
                KIND_MODE:
                begin
                    if (bi == 1) cb = CMD_SETMODE;
                    else if (bi == 3) cb = cfg.analog_select ? MODE_ANALOG : MODE_DIGITAL;
                    else if (bi == 4) cb = cfg.mode_lock ? LOCK_CODE : UNLOCK_CODE;
                end
                KIND_EXIT:
                begin
                    if (bi == 1) cb = CMD_CONFIG;
                    else if (bi >= 4 && bi <= 8) cb = EXIT_PAD;
                end
                default:
                begin
                    cb = 8'h00;
                end
            endcase
        end
        return cb;
    endfunction

    // Lowest zero bit plus one, zero when no button is pressed.
    function automatic logic [4:0] lowest_pressed(input logic [15:0] btn);
        logic [4:0] key;
        key = 5'd0;
        for (int k = 15; k >= 0; k--) begin
            if (!btn[k]) key = 5'(k + 1);
        end
        return key;
    endfunction

endpackage

FILE: sv/gamepad_serial_poll_master.sv
// ============================================================================
// gamepad_serial_poll_master
// Bit-slot master for the gamepad serial link with decoded pad state.
// ============================================================================
// Each item pushed into this block is one bit slot of the gamepad link, and
// each item yields exactly one result, in order. An action given while the
// block is idle starts a poll, a motor poll, the init sequence or a mode
// check; the slot carrying it is already bit zero of the first byte, and
// actions arriving while a frame runs are ignored. The block sustains one
// item per clock while the result queue has space: the slot engine updates
// its frame counters, shift register and reply bytes as each item passes.
// A result reaches the result ports after its item has waited in the input
// queue and the engine has written its result straight into the result
// queue. Both two-entry queues let either side stall without losing
// throughput.
// Configuration (analog_select at index 0, mode_lock at index 1) must be
// written while no item is in flight; writes are always accepted and writes
// to other indexes are dropped. No clearing pass is needed after reset.
module gamepad_serial_poll_master (
    input  logic        clk,
    input  logic        rst_n,
    // Input item channel.
    input  logic        push,
    output logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  motor_small,
    input  logic [7:0]  motor_large,
    input  logic        miso,
    // Result channel.
    output logic        empty,
    input  logic        pop,
    output logic        select_active,
    output logic        mosi,
    output logic        busy_res,
    output logic        frame_done,
    output logic [15:0] buttons,
    output logic [4:0]  pressed_key,
    output logic [7:0]  right_x,
    output logic [7:0]  right_y,
    output logic [7:0]  left_x,
    output logic [7:0]  left_y,
    output logic [7:0]  mode_byte,
    output logic        not_analog,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    gpsp_pkg::cfg_t     cfg_reg, cfg_next;
    gpsp_pkg::cmd_t     cmd_head;
    gpsp_pkg::result_t  res_data;
    gpsp_pkg::result_t  res_head;
    logic               cmd_empty;
    logic               cmd_pop;
    logic               res_push;
    logic               res_full;

    // The configuration registers are simple flops that accept a write on
    // every cycle; the engine reads them only while building set-mode bytes.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gpsp_pkg::REG_ANALOG_SELECT)
                cfg_next.analog_select = cfg_data;
            else if (cfg_index == gpsp_pkg::REG_MODE_LOCK)
                cfg_next.mode_lock = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.analog_select <= 1'b1;
            cfg_reg.mode_lock     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front side classifies each slot and holds it until the engine
    // has room to produce its result.
    gpsp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .motor_small (motor_small),
        .motor_large (motor_large),
        .miso        (miso),
        .cmd_pop     (cmd_pop),
        .cmd_empty   (cmd_empty),
        .cmd_head    (cmd_head)
    );

    // The engine runs one slot per cycle whenever a slot is queued and the
    // result queue has space.
    gpsp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    gpsp_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_head (res_head)
    );

    assign select_active = res_head.select_active;
    assign mosi          = res_head.mosi;
    assign busy_res      = res_head.busy_res;
    assign frame_done    = res_head.frame_done;
    assign buttons       = res_head.buttons;
    assign pressed_key   = res_head.pressed_key;
    assign right_x       = res_head.right_x;
    assign right_y       = res_head.right_y;
    assign left_x        = res_head.left_x;
    assign left_y        = res_head.left_y;
    assign mode_byte     = res_head.mode_byte;
    assign not_analog    = res_head.not_analog;

`ifndef SYNTHESIS
    // A frame can only finish in a selected slot of a busy action.
    a_done_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.frame_done) |-> (res_data.select_active && res_data.busy_res))
        else $error("frame completion outside a selected busy slot");

    // Command bits are driven only while chip select is asserted.
    a_mosi_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.mosi) |-> res_data.select_active)
        else $error("mosi driven while deselected");

    // The engine only produces a result when it has consumed a slot.
    a_push_pop_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (cmd_pop && !cmd_empty && !res_full))
        else $error("result produced without a consumed slot");

    // A slot pushed into an empty pipeline can be popped once its result is queued.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && cmd_empty && empty && !pop) |=> ##1 !empty)
        else $error("result missing after accepted slot");
`endif

endmodule

FILE: sv/gpsp_front.sv
// ============================================================================
// gpsp_front
// Accepts bit-slot items, classifies the action and queues them for the engine.
// ============================================================================
module gpsp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           action,
    input  logic [7:0]           motor_small,
    input  logic [7:0]           motor_large,
    input  logic                 miso,
    input  logic                 cmd_pop,
    output logic                 cmd_empty,
    output gpsp_pkg::cmd_t       cmd_head
);

    gpsp_pkg::cmd_t                 mem_reg [gpsp_pkg::Q_DEPTH];
    logic [gpsp_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [gpsp_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [gpsp_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    gpsp_pkg::cmd_t                 item;
    logic                           wr_en;
    logic                           rd_en;

    // Only actions one to four can start anything; the rest travel as no action.
    always_comb
    begin
        item.start       = (action == gpsp_pkg::ACT_POLL)  || (action == gpsp_pkg::ACT_MOTOR) ||
                           (action == gpsp_pkg::ACT_INIT)  || (action == gpsp_pkg::ACT_CHECK);
        item.action      = item.start ? gpsp_pkg::action_t'(action) : gpsp_pkg::ACT_NONE;
        item.motor_small = motor_small;
        item.motor_large = motor_large;
        item.miso        = miso;
    end

    assign full      = (count_reg == gpsp_pkg::Q_CNT_W'(gpsp_pkg::Q_DEPTH));
    assign cmd_empty = (count_reg == '0);
    assign cmd_head  = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && !cmd_empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gpsp_pkg::Q_CNT_W'(wr_en) - gpsp_pkg::Q_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: sv/gpsp_engine.sv
// ============================================================================
// gpsp_engine
// Runs one bit slot per queued item: frame sequencing, shifting and decoding.
// ============================================================================
module gpsp_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gpsp_pkg::cfg_t       cfg,
    input  logic                 cmd_empty,
    input  gpsp_pkg::cmd_t       cmd_head,
    output logic                 cmd_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output gpsp_pkg::result_t    res_data
);

    gpsp_pkg::action_t              act_reg, act_next, act_e;
    logic [gpsp_pkg::STEP_W-1:0]    step_reg, step_next, step_e;
    logic [gpsp_pkg::BYTE_W-1:0]    byte_reg, byte_next, byte_e, byte_inc;
    logic [2:0]                     bit_reg, bit_next, bit_e;
    logic                           gap_reg, gap_next, gap_e;
    logic [7:0]                     small_reg, small_next;
    logic [7:0]                     large_reg, large_next;
    logic [7:0]                     shift_reg, shift_next;
    logic [7:0]                     reply_reg  [gpsp_pkg::REPLY_DEPTH];
    logic [7:0]                     reply_next [gpsp_pkg::REPLY_DEPTH];
    logic                           fire;
    logic                           start;
    logic                           last;
    logic [7:0]                     cb;
    logic [15:0]                    btn;

    assign fire     = !cmd_empty && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;
    assign start    = (act_reg == gpsp_pkg::ACT_NONE) && cmd_head.start;

    always_comb
    begin
        // A start slot is already bit zero of byte zero of the first frame.
        act_e      = start ? cmd_head.action : act_reg;
        step_e     = start ? '0 : step_reg;
        byte_e     = start ? '0 : byte_reg;
        bit_e      = start ? '0 : bit_reg;
        gap_e      = start ? 1'b0 : gap_reg;
        small_next = start ? cmd_head.motor_small : small_reg;
        large_next = start ? cmd_head.motor_large : large_reg;

        act_next   = act_e;
        step_next  = step_e;
        byte_next  = byte_e;
        bit_next   = bit_e;
        gap_next   = gap_e;
        shift_next = shift_reg;
        for (int i = 0; i < gpsp_pkg::REPLY_DEPTH; i++)
        begin
            reply_next[i] = reply_reg[i];
        end

        cb       = gpsp_pkg::cmd_byte(act_e, step_e, byte_e, small_next, large_next, cfg);
        byte_inc = byte_e + 1'b1;
        last     = (act_e != gpsp_pkg::ACT_INIT) ||
                   (int'(step_e) >= gpsp_pkg::SHORT_POLLS + 2);

        res_data = '0;

        if (act_e != gpsp_pkg::ACT_NONE)
        begin
            res_data.busy_res = 1'b1;
            if (gap_e)
            begin
                gap_next = 1'b0;
            end
            else
            begin
                res_data.select_active = 1'b1;
                res_data.mosi          = cb[bit_e];
                shift_next             = {cmd_head.miso, shift_reg[7:1]};
                if (bit_e == 3'd7)
                begin
                    bit_next = '0;
                    if (act_e != gpsp_pkg::ACT_INIT)
                    begin
                        for (int i = 0; i < gpsp_pkg::REPLY_DEPTH; i++)
                        begin
                            if (int'(byte_e) == i) reply_next[i] = shift_next;
                        end
                    end
                    if (byte_inc >= gpsp_pkg::frame_len(act_e, step_e))
                    begin
                        byte_next = '0;
                        if (last)
                        begin
                            act_next            = gpsp_pkg::ACT_NONE;
                            step_next           = '0;
                            res_data.frame_done = 1'b1;
                        end
                        else
                        begin
                            step_next = step_e + 1'b1;
                            gap_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_next = byte_inc;
                    end
                end
                else
                begin
                    bit_next = bit_e + 1'b1;
                end
            end
        end

        btn                  = {reply_next[4], reply_next[3]};
        res_data.buttons     = btn;
        res_data.pressed_key = gpsp_pkg::lowest_pressed(btn);
        res_data.right_x     = reply_next[5];
        res_data.right_y     = reply_next[6];
        res_data.left_x      = reply_next[7];
        res_data.left_y      = reply_next[8];
        res_data.mode_byte   = reply_next[1];
        res_data.not_analog  = (reply_next[1] != gpsp_pkg::ID_ANALOG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= gpsp_pkg::ACT_NONE;
            step_reg  <= '0;
            byte_reg  <= '0;
            bit_reg   <= '0;
            gap_reg   <= 1'b0;
            small_reg <= '0;
            large_reg <= '0;
            shift_reg <= '0;
            for (int i = 0; i < gpsp_pkg::REPLY_DEPTH; i++)
            begin
                reply_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            act_reg   <= act_next;
            step_reg  <= step_next;
            byte_reg  <= byte_next;
            bit_reg   <= bit_next;
            gap_reg   <= gap_next;
            small_reg <= small_next;
            large_reg <= large_next;
            shift_reg <= shift_next;
            for (int i = 0; i < gpsp_pkg::REPLY_DEPTH; i++)
            begin
                reply_reg[i] <= reply_next[i];
            end
        end
    end

endmodule

FILE: sv/gpsp_result_queue.sv
// ============================================================================
// gpsp_result_queue
// Two-entry queue holding finished results until the consumer pops them.
// ============================================================================
module gpsp_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    input  gpsp_pkg::result_t    res_data,
    output logic                 res_full,
    input  logic                 pop,
    output logic                 empty,
    output gpsp_pkg::result_t    res_head
);

    gpsp_pkg::result_t              mem_reg [gpsp_pkg::Q_DEPTH];
    logic [gpsp_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [gpsp_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [gpsp_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                           wr_en;
    logic                           rd_en;

    assign res_full = (count_reg == gpsp_pkg::Q_CNT_W'(gpsp_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign res_head = mem_reg[rd_ptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gpsp_pkg::Q_CNT_W'(wr_en) - gpsp_pkg::Q_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

FILE: verif/gamepad_serial_poll_master_checker.sv
// ============================================================================
// gamepad_serial_poll_master_checker
// Watches the slot, result and register channels of the gamepad poll master,
// predicts the pad state for every accepted bit slot and compares it field by
// field with the result that the block returns.
// ============================================================================
module gamepad_serial_poll_master_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  motor_small,
    input  logic [7:0]  motor_large,
    input  logic        miso,
    input  logic        empty,
    input  logic        pop,
    input  logic        select_active,
    input  logic        mosi,
    input  logic        busy_res,
    input  logic        frame_done,
    input  logic [15:0] buttons,
    input  logic [4:0]  pressed_key,
    input  logic [7:0]  right_x,
    input  logic [7:0]  right_y,
    input  logic [7:0]  left_x,
    input  logic [7:0]  left_y,
    input  logic [7:0]  mode_byte,
    input  logic        not_analog,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    output int          mismatches,
    output int          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Register copies.
    logic       analog_sel_q;
    logic       mode_lock_q;

    // Link state of the modeled master.
    gpsp_pkg::action_t run_act;
    logic [2:0] bit_pos;
    logic [3:0] byte_pos;
    logic [2:0] seq_step;
    logic [7:0] rx_shift;
    logic [7:0] reply_mem [gpsp_pkg::REPLY_DEPTH];
    logic       gap_slot;
    logic [7:0] motor_small_q;
    logic [7:0] motor_large_q;

    gpsp_pkg::result_t pad_results_due [$];
    gpsp_pkg::result_t got_slot;
    gpsp_pkg::result_t want_slot;
    int         results_seen;

    function automatic gpsp_pkg::kind_t init_frame_of_step();
        gpsp_pkg::kind_t k;
        if (int'(seq_step) < gpsp_pkg::SHORT_POLLS)
            k = gpsp_pkg::KIND_SHORT;
        else
            k = gpsp_pkg::kind_t'(2'(int'(seq_step) - gpsp_pkg::SHORT_POLLS + 1));
        return k;
    endfunction

    // Advances the modeled link by one bit slot and returns the pad state
    // that the block must report for it.
    function automatic gpsp_pkg::result_t next_pad_state(input logic [2:0] act_in,
                                                         input logic [7:0] small_in,
                                                         input logic [7:0] large_in,
                                                         input logic       miso_in);
        gpsp_pkg::result_t r;
        logic [7:0] cmd;
        logic [15:0] btn;
        int         frame_bytes;
        r = '0;
        if (run_act == gpsp_pkg::ACT_NONE && act_in >= gpsp_pkg::ACT_POLL &&
            act_in <= gpsp_pkg::ACT_CHECK)
        begin
            run_act       = gpsp_pkg::action_t'(act_in);
            seq_step      = '0;
            byte_pos      = '0;
            bit_pos       = '0;
            gap_slot      = 1'b0;
            motor_small_q = small_in;
            motor_large_q = large_in;
        end
        if (run_act != gpsp_pkg::ACT_NONE)
        begin
            r.busy_res = 1'b1;
            if (gap_slot)
            begin
                gap_slot = 1'b0;
            end
            else
            begin
                cmd = 8'h00;
                if (byte_pos == 0)
                    cmd = gpsp_pkg::CMD_START;
                else if (run_act != gpsp_pkg::ACT_INIT)
                begin
                    if (byte_pos == 1)
                        cmd = gpsp_pkg::CMD_POLL;
                    else if (run_act == gpsp_pkg::ACT_MOTOR && byte_pos == 3)
                        cmd = motor_small_q;
                    else if (run_act == gpsp_pkg::ACT_MOTOR && byte_pos == 4)
                        cmd = motor_large_q;
                end
                else
                begin
                    case (init_frame_of_step())
                        gpsp_pkg::KIND_SHORT:
                        begin
                            if (byte_pos == 1) cmd = gpsp_pkg::CMD_POLL;
                        end
                        gpsp_pkg::KIND_ENTER:
                        begin
                            if (byte_pos == 1) cmd = gpsp_pkg::CMD_CONFIG;
                            else if (byte_pos == 3) cmd = gpsp_pkg::ENTER_ON;
                        end
                        gpsp_pkg::KIND_MODE:
                        begin
                            if (byte_pos == 1)
                                cmd = gpsp_pkg::CMD_SETMODE;
                            else if (byte_pos == 3)
                                cmd = analog_sel_q ? gpsp_pkg::MODE_ANALOG
                                                   : gpsp_pkg::MODE_DIGITAL;
                            else if (byte_pos == 4)
                                cmd = mode_lock_q ? gpsp_pkg::LOCK_CODE
                                                  : gpsp_pkg::UNLOCK_CODE;
                        end
                        default:
                        begin
                            if (byte_pos == 1)
                                cmd = gpsp_pkg::CMD_CONFIG;
                            else if (byte_pos >= 4 && byte_pos <= 8)
                                cmd = gpsp_pkg::EXIT_PAD;
                        end
                    endcase
                end
                r.select_active = 1'b1;
                r.mosi          = cmd[bit_pos];
                rx_shift        = {miso_in, rx_shift[7:1]};
                if (bit_pos == 3'd7)
                begin
                    bit_pos = '0;
                    if (run_act != gpsp_pkg::ACT_INIT && byte_pos < gpsp_pkg::REPLY_DEPTH)
                        reply_mem[byte_pos] = rx_shift;
                    byte_pos++;
                    if (run_act == gpsp_pkg::ACT_CHECK)
                        frame_bytes = gpsp_pkg::CHECK_LEN;
                    else if (run_act == gpsp_pkg::ACT_INIT &&
                             init_frame_of_step() == gpsp_pkg::KIND_SHORT)
                        frame_bytes = gpsp_pkg::SHORT_LEN;
                    else
                        frame_bytes = gpsp_pkg::FRAME_LEN;
                    if (byte_pos >= frame_bytes)
                    begin
                        byte_pos = '0;
                        if (run_act != gpsp_pkg::ACT_INIT ||
                            int'(seq_step) >= gpsp_pkg::SHORT_POLLS + 2)
                        begin
                            run_act      = gpsp_pkg::ACT_NONE;
                            seq_step     = '0;
                            r.frame_done = 1'b1;
                        end
                        else
                        begin
                            seq_step++;
                            gap_slot = 1'b1;
                        end
                    end
                end
                else
                begin
                    bit_pos++;
                end
            end
        end
        btn       = {reply_mem[4], reply_mem[3]};
        r.buttons = btn;
        for (int k = 0; k < 16; k++)
        begin
            if (r.pressed_key == 0 && !btn[k])
                r.pressed_key = 5'(k + 1);
        end
        r.right_x    = reply_mem[5];
        r.right_y    = reply_mem[6];
        r.left_x     = reply_mem[7];
        r.left_y     = reply_mem[8];
        r.mode_byte  = reply_mem[1];
        r.not_analog = (reply_mem[1] != gpsp_pkg::ID_ANALOG);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("slot result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            analog_sel_q  <= 1'b1;
            mode_lock_q   <= 1'b1;
            run_act       = gpsp_pkg::ACT_NONE;
            bit_pos       = '0;
            byte_pos      = '0;
            seq_step      = '0;
            rx_shift      = '0;
            gap_slot      = 1'b0;
            motor_small_q = '0;
            motor_large_q = '0;
            for (int i = 0; i < gpsp_pkg::REPLY_DEPTH; i++)
                reply_mem[i] = '0;
            pad_results_due.delete();
            results_seen  = 0;
            mismatches    = 0;
            pending       = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gpsp_pkg::REG_ANALOG_SELECT: analog_sel_q <= cfg_data;
                    gpsp_pkg::REG_MODE_LOCK:     mode_lock_q  <= cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                pad_results_due.push_back(
                    next_pad_state(action, motor_small, motor_large, miso));
            if (pop && !empty)
            begin
                got_slot = {select_active, mosi, busy_res, frame_done, buttons,
                            pressed_key, right_x, right_y, left_x, left_y,
                            mode_byte, not_analog};
                if (pad_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("slot result %0d arrived with none outstanding: 0x%0h",
                                 results_seen, got_slot);
                end
                else
                begin
                    want_slot = pad_results_due.pop_front();
                    check_field("select_active", want_slot.select_active,
                                got_slot.select_active);
                    check_field("mosi", want_slot.mosi, got_slot.mosi);
                    check_field("busy_res", want_slot.busy_res, got_slot.busy_res);
                    check_field("frame_done", want_slot.frame_done, got_slot.frame_done);
                    check_field("buttons", want_slot.buttons, got_slot.buttons);
                    check_field("pressed_key", want_slot.pressed_key,
                                got_slot.pressed_key);
                    check_field("right_x", want_slot.right_x, got_slot.right_x);
                    check_field("right_y", want_slot.right_y, got_slot.right_y);
                    check_field("left_x", want_slot.left_x, got_slot.left_x);
                    check_field("left_y", want_slot.left_y, got_slot.left_y);
                    check_field("mode_byte", want_slot.mode_byte, got_slot.mode_byte);
                    check_field("not_analog", want_slot.not_analog, got_slot.not_analog);
                end
                results_seen++;
            end
            pending = pad_results_due.size();
        end
    end

endmodule

FILE: verif/gamepad_serial_poll_master_tb.sv
// ============================================================================
// gamepad_serial_poll_master_tb
// Drives bit slots into the gamepad poll master and gives the verdict.
// ============================================================================
// Frames are sent as whole, well-formed slot sequences: the slot that carries
// the action and the slots after it make up exactly the frame's length, so the
// next action always lands on an idle master. Reply bits are shaped per frame
// so that the decoded buttons, the pressed key, the sticks and the mode byte
// all see their extremes as well as random values. Checking is left to the
// checker module, which predicts every result on its own.
module gamepad_serial_poll_master_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD_NS    = 10;
    localparam int RESET_CYCLES     = 12;
    // Slot budget of the random part, shared evenly by its phases. The
    // directed frames and the init sequence of the first phase bring the
    // whole run to roughly 1150 slots.
    localparam int RANDOM_ITEMS     = 128;
    localparam int PHASES           = 4;
    localparam int CONFIG_FRAMES    = 3;
    // Two queue stages in the block; the settle time covers them with room.
    localparam int SETTLE_CYCLES    = 6;
    localparam int LONG_HOLD_CYCLES = 60;
    // Far beyond the slowest legal run, even with both sides stalling.
    localparam int WATCHDOG_NS      = 5_000_000;

    localparam logic [2:0] ACT_CODE_TOP = '1;
    localparam logic [7:0] ID_DIGITAL   = 8'h41;

    // Register settings per random phase; bit p belongs to phase p.
    localparam logic [PHASES-1:0] PHASE_ANALOG = 4'b1010;
    localparam logic [PHASES-1:0] PHASE_LOCK   = 4'b1100;

    // How the controller side answers during one frame.
    typedef enum int {
        REPLY_RANDOM,
        REPLY_ONES,
        REPLY_ZEROS,
        REPLY_PAD
    } reply_style_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [2:0]  action      = '0;
    logic [7:0]  motor_small = '0;
    logic [7:0]  motor_large = '0;
    logic        miso        = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic        select_active;
    logic        mosi;
    logic        busy_res;
    logic        frame_done;
    logic [15:0] buttons;
    logic [4:0]  pressed_key;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  mode_byte;
    logic        not_analog;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = '0;
    logic        cfg_data    = 1'b0;

    int          mismatches;
    int          pending;

    // Idling levels in percent, changed by the stimulus between phases.
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    // Long receiver hold-offs requested by the stimulus and carried out by
    // the receiver process.
    int          holds_asked     = 0;
    int          holds_served    = 0;
    int          slots_sent      = 0;

    gamepad_serial_poll_master u_dut (.*);

    gamepad_serial_poll_master_checker u_checker (.*);

    always #(CLK_PERIOD_NS / 2) clk = ~clk;

    // Offers one bit slot and returns at the clock edge that takes it. The
    // push line is never lowered here after acceptance; the next call or the
    // drain task decides its level, so it changes at most once per edge.
    task automatic send_slot(input logic [2:0] act, input logic [7:0] small_b,
                             input logic [7:0] large_b, input logic bit_in);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            push        <= 1'b0;
            action      <= 3'($urandom);
            motor_small <= 8'($urandom);
            motor_large <= 8'($urandom);
            miso        <= 1'($urandom);
            @(posedge clk);
        end
        push        <= 1'b1;
        action      <= act;
        motor_small <= small_b;
        motor_large <= large_b;
        miso        <= bit_in;
        @(posedge clk);
        while (full)
            @(posedge clk);
        slots_sent++;
    endtask

    // Stops offering slots until every result has come back, then lets
    // the given number of cycles pass.
    task automatic wait_drained(input int extra);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input gpsp_pkg::reg_index_t idx, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Both registers are written back to back; valid drops only after the
    // second one is taken.
    task automatic program_pad_mode(input logic analog, input logic lock);
        write_reg(gpsp_pkg::REG_ANALOG_SELECT, analog);
        write_reg(gpsp_pkg::REG_MODE_LOCK, lock);
        cfg_valid <= 1'b0;
    endtask

    // Sends one complete action. Slot zero carries the action and the motor
    // bytes; the remaining slots of the frame carry mostly no action, with
    // some random codes that the busy master must ignore. Reply bytes go out
    // least significant bit first, one new byte every eight slots.
    task automatic run_frame(input logic [2:0] act, input reply_style_t style,
                             input logic [7:0] small_b, input logic [7:0] large_b);
        int         n_slots;
        int         pos;
        logic [7:0] reply;
        logic [2:0] slot_act;
        reply = '0;
        if (act == gpsp_pkg::ACT_POLL || act == gpsp_pkg::ACT_MOTOR)
            n_slots = gpsp_pkg::FRAME_LEN * 8;
        else if (act == gpsp_pkg::ACT_CHECK)
            n_slots = gpsp_pkg::CHECK_LEN * 8;
        else if (act == gpsp_pkg::ACT_INIT)
            // Short polls, the three configuration frames and one gap slot
            // between each pair of frames.
            n_slots = (gpsp_pkg::SHORT_POLLS * gpsp_pkg::SHORT_LEN +
                       CONFIG_FRAMES * gpsp_pkg::FRAME_LEN) * 8
                      + gpsp_pkg::SHORT_POLLS + CONFIG_FRAMES - 1;
        else
            n_slots = 1;
        for (int j = 0; j < n_slots; j++)
        begin
            if (j % 8 == 0)
            begin
                pos = j / 8;
                case (style)
                    REPLY_ONES:  reply = 8'hFF;
                    REPLY_ZEROS: reply = 8'h00;
                    REPLY_PAD:
                    begin
                        // A plausible pad: a known mode byte, at most one
                        // pressed button per byte, sticks anywhere.
                        if (pos == 1)
                            reply = ($urandom_range(1) != 0) ? gpsp_pkg::ID_ANALOG
                                                             : ID_DIGITAL;
                        else if (pos == 3 || pos == 4)
                            reply = ($urandom_range(3) == 0) ? 8'hFF
                                    : ~(8'h01 << $urandom_range(7));
                        else
                            reply = 8'($urandom);
                    end
                    default: reply = 8'($urandom);
                endcase
            end
            if (j == 0)
            begin
                send_slot(act, small_b, large_b, reply[0]);
            end
            else
            begin
                slot_act = ($urandom_range(99) < 10) ? 3'($urandom) : gpsp_pkg::ACT_NONE;
                send_slot(slot_act, 8'($urandom), 8'($urandom), reply[j % 8]);
            end
        end
    endtask

    // The receiver: pops at the rate of the current phase, and on request
    // holds off for a long stretch so that both queues fill and the block
    // refuses further slots.
    initial
    begin
        forever
        begin
            if (holds_served < holds_asked)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
            begin
                pop <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [2:0]   act;
        logic [7:0]   small_b;
        logic [7:0]   large_b;
        int           pick;
        int           phase_end;
        int           frames_in_phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset settings written explicitly.
        program_pad_mode(1'b1, 1'b1);
        // Idle slots with no action and with the unused codes leave the
        // master idle and the stored reply bytes at zero.
        run_frame(gpsp_pkg::ACT_NONE, REPLY_RANDOM, 8'hFF, 8'hFF);
        for (int a = int'(gpsp_pkg::ACT_CHECK) + 1; a <= int'(ACT_CODE_TOP); a++)
            run_frame(3'(a), REPLY_RANDOM, 8'hFF, 8'hFF);
        // The check, poll and motor frames with the extremes of the reply and motor bytes.
        run_frame(gpsp_pkg::ACT_CHECK, REPLY_ZEROS, 8'h00, 8'h00);
        run_frame(gpsp_pkg::ACT_POLL, REPLY_ONES, 8'h00, 8'h00);
        run_frame(gpsp_pkg::ACT_MOTOR, REPLY_ZEROS, 8'hFF, 8'h00);
        run_frame(gpsp_pkg::ACT_MOTOR, REPLY_PAD, 8'h00, 8'hFF);
        // The init sequence must leave the stored reply bytes untouched.
        run_frame(gpsp_pkg::ACT_INIT, REPLY_RANDOM, 8'hA5, 8'h5A);
        run_frame(gpsp_pkg::ACT_CHECK, REPLY_PAD, 8'h00, 8'h00);

        // Random part: one register setting and one idling pattern per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained(SETTLE_CYCLES);
            program_pad_mode(PHASE_ANALOG[p], PHASE_LOCK[p]);
            case (p)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 58;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 58;
                end
                default:
                begin
                    sender_idle_pct = 18;
                    recv_stall_pct  = 18;
                end
            endcase
            phase_end       = slots_sent + RANDOM_ITEMS / PHASES;
            frames_in_phase = 0;
            if (p == 0)
            begin
                // Long receiver hold-off while the init sequence streams in
                // at full rate with both register bits cleared.
                holds_asked++;
                run_frame(gpsp_pkg::ACT_INIT, REPLY_RANDOM, 8'($urandom), 8'($urandom));
                frames_in_phase++;
            end
            while (slots_sent < phase_end)
            begin
                // At most once, the sender waits for the pipeline to run dry.
                if (p == 2 && frames_in_phase == 1)
                    wait_drained(0);
                pick = $urandom_range(99);
                if (pick < 30)
                    act = gpsp_pkg::ACT_POLL;
                else if (pick < 55)
                    act = gpsp_pkg::ACT_MOTOR;
                else if (pick < 80)
                    act = gpsp_pkg::ACT_CHECK;
                else if (pick < 82)
                    act = gpsp_pkg::ACT_INIT;
                else if (pick < 91)
                    act = gpsp_pkg::ACT_NONE;
                else
                    act = 3'($urandom_range(int'(ACT_CODE_TOP),
                                            int'(gpsp_pkg::ACT_CHECK) + 1));
                small_b = 8'($urandom);
                large_b = 8'($urandom);
                if ($urandom_range(4) == 0)
                    small_b = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                if ($urandom_range(4) == 0)
                    large_b = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                run_frame(act, reply_style_t'($urandom_range(3)), small_b, large_b);
                frames_in_phase++;
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/gpsp_pkg.sv
sv/gpsp_front.sv
sv/gpsp_engine.sv
sv/gpsp_result_queue.sv
sv/gamepad_serial_poll_master.sv
verif/gamepad_serial_poll_master_checker.sv
verif/gamepad_serial_poll_master_tb.sv
